### src/yrgb_pkg.sv
// shared constants, types and the channel finishing function for the yuv to rgb24 pair unit
package yrgb_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned IN_W     = 4 * SAMPLE_W;
  localparam int unsigned OUT_W    = 6 * SAMPLE_W;

  // q10 channel sums fit in 21 signed bits for every input pattern
  localparam int unsigned SUM_W  = 21;
  localparam int unsigned FRAC_W = 10;
  localparam int unsigned CINT_W = SUM_W - 1 - FRAC_W;

  localparam logic signed [SUM_W-1:0] LUMA_OFS   = 21'sd16;
  localparam logic signed [SUM_W-1:0] CHROMA_OFS = 21'sd128;
  localparam logic signed [SUM_W-1:0] Q_LUMA     = 21'sd1192;
  localparam logic signed [SUM_W-1:0] Q_CB_BLUE  = 21'sd2066;
  localparam logic signed [SUM_W-1:0] Q_CR_GREEN = 21'sd833;
  localparam logic signed [SUM_W-1:0] Q_CB_GREEN = 21'sd400;
  localparam logic signed [SUM_W-1:0] Q_CR_RED   = 21'sd1634;

  // c*220/250 = c*22/25; below the clamp point c*22 < 6400, so /25 is
  // exact as (c * 22 * ceil(2^18/25)) >> 18
  localparam int unsigned MANT_W    = 9;
  localparam int unsigned RECIP_SH  = 18;
  localparam int unsigned PROD_W    = MANT_W + RECIP_SH;
  localparam logic [PROD_W-1:0] SCALE_MUL = 27'd230692;
  localparam logic [CINT_W-1:0] SAT_LIMIT = 10'd291;

  typedef struct packed {
    logic signed [SUM_W-1:0] red;
    logic signed [SUM_W-1:0] green;
    logic signed [SUM_W-1:0] blue;
  } chroma_terms_t;

  typedef struct packed {
    logic              neg;
    logic              sat;
    logic [PROD_W-1:0] prod;
  } chan_raw_t;

  typedef struct packed {
    chan_raw_t red;
    chan_raw_t green;
    chan_raw_t blue;
  } pix_raw_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  function automatic logic [SAMPLE_W-1:0] finish_chan(input chan_raw_t ch);
    logic [SAMPLE_W-1:0] res;
    res = ch.prod[RECIP_SH +: SAMPLE_W];
    if (ch.neg) begin
      res = '0;
    end else if (ch.sat) begin
      res = '1;
    end
    return res;
  endfunction

endpackage

### src/yrgb_chroma.sv
// shared chroma contributions, computed once per pair and handed to both lanes
module yrgb_chroma (
  input  logic                           clk,
  input  yrgb_pkg::stage_en_t            en,
  input  logic [yrgb_pkg::SAMPLE_W-1:0]  chroma_blue,
  input  logic [yrgb_pkg::SAMPLE_W-1:0]  chroma_red,
  output yrgb_pkg::chroma_terms_t        terms
);
  import yrgb_pkg::*;

  logic signed [SUM_W-1:0] ud;
  logic signed [SUM_W-1:0] vd;
  chroma_terms_t           terms_r;
  chroma_terms_t           terms_nxt;

  always_comb begin
    ud = signed'(SUM_W'(chroma_blue)) - CHROMA_OFS;
    vd = signed'(SUM_W'(chroma_red)) - CHROMA_OFS;
    terms_nxt.red   = Q_CR_RED * vd;
    terms_nxt.green = -(Q_CR_GREEN * vd) - (Q_CB_GREEN * ud);
    terms_nxt.blue  = Q_CB_BLUE * ud;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms = terms_r;

endmodule

### src/yrgb_lane.sv
// one pixel lane: luma product, three channel sums and the rescale product
module yrgb_lane (
  input  logic                          clk,
  input  yrgb_pkg::stage_en_t           en,
  input  logic [yrgb_pkg::SAMPLE_W-1:0] luma,
  input  yrgb_pkg::chroma_terms_t       terms,
  output yrgb_pkg::pix_raw_t            pix
);
  import yrgb_pkg::*;

  logic signed [SUM_W-1:0] yd;
  logic signed [SUM_W-1:0] ly_r;
  logic signed [SUM_W-1:0] ly_nxt;
  pix_raw_t                pix_r;
  pix_raw_t                pix_nxt;

  // negative sums clamp to zero whatever the truncation does
  function automatic chan_raw_t chan_step(input logic signed [SUM_W-1:0] sum);
    chan_raw_t          ch;
    logic [CINT_W-1:0]  cint;
    cint    = sum[FRAC_W +: CINT_W];
    ch.neg  = sum[SUM_W-1];
    ch.sat  = (cint >= SAT_LIMIT);
    ch.prod = PROD_W'(cint[MANT_W-1:0]) * SCALE_MUL;
    return ch;
  endfunction

  always_comb begin
    yd     = signed'(SUM_W'(luma)) - LUMA_OFS;
    ly_nxt = Q_LUMA * yd;
    pix_nxt.red   = chan_step(ly_r + terms.red);
    pix_nxt.green = chan_step(ly_r + terms.green);
    pix_nxt.blue  = chan_step(ly_r + terms.blue);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ly_r <= ly_nxt;
    end
    if (en.s2) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix = pix_r;

endmodule

### src/yuv_to_rgb24_pixel_pair_unit.sv
// top level: two pixel lanes, shared chroma terms and the merging output register
//
// Converts one YCbCr pixel pair (two luma samples sharing one Cb/Cr pair) into
// two RGB24 pixels with BT.601-style Q10 coefficients, a 220/250 rescale and
// clamping to 0..255. One pair is taken every clock unless out_tready back-pressure
// fills the stages; a result passes through the three register stages (products,
// channel sums with rescale, clamp and packing). Each stage stalls only when it
// holds data that the next stage cannot take, so bubbles are squeezed out and
// in_tready stays high while the output register is full but earlier stages
// are free. No state is kept between pairs; reset only clears the valid flags.
module yuv_to_rgb24_pixel_pair_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // luma_first, luma_second, chroma_blue, chroma_red
  input  logic [yrgb_pkg::IN_W-1:0]    in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // red_first, green_first, blue_first, red_second, green_second, blue_second
  output logic [yrgb_pkg::OUT_W-1:0]   out_tdata
);
  import yrgb_pkg::*;

  logic              v1_r;
  logic              v2_r;
  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_tdata_r;
  logic [OUT_W-1:0]  out_tdata_nxt;
  logic              rdy1;
  logic              rdy2;
  logic              rdy3;
  stage_en_t         en;
  chroma_terms_t     terms;
  pix_raw_t          pix_first;
  pix_raw_t          pix_second;

  assign rdy3 = !out_tvalid_r || out_tready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign in_tready = rdy1;

  yrgb_chroma u_chroma (
    .clk         (clk),
    .en          (en),
    .chroma_blue (in_tdata[2*SAMPLE_W +: SAMPLE_W]),
    .chroma_red  (in_tdata[3*SAMPLE_W +: SAMPLE_W]),
    .terms       (terms)
  );

  yrgb_lane u_lane_first (
    .clk   (clk),
    .en    (en),
    .luma  (in_tdata[0 +: SAMPLE_W]),
    .terms (terms),
    .pix   (pix_first)
  );

  yrgb_lane u_lane_second (
    .clk   (clk),
    .en    (en),
    .luma  (in_tdata[SAMPLE_W +: SAMPLE_W]),
    .terms (terms),
    .pix   (pix_second)
  );

  // merge both lanes into one packed result
  always_comb begin
    out_tdata_nxt = {finish_chan(pix_second.blue), finish_chan(pix_second.green),
                     finish_chan(pix_second.red),  finish_chan(pix_first.blue),
                     finish_chan(pix_first.green), finish_chan(pix_first.red)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        out_tvalid_r <= v2_r;
      end
    end
    if (rdy3) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### tb/sv/yuv_to_rgb24_pixel_pair_unit_tb.sv
// testbench for the yuv to rgb24 pixel pair unit: stream stimulus, conversion predictor, checker
module yuv_to_rgb24_pixel_pair_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import yrgb_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES = 60;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_REPORTS = 30;

  // index 0..5 follows the out_tdata byte order
  typedef logic [5:0][SAMPLE_W-1:0] rgb_pair_t;
  typedef logic [2:0][SAMPLE_W-1:0] rgb_pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  rgb_pair_t rgb_due[$];
  string chan_name[6] = '{"red_first", "green_first", "blue_first",
                          "red_second", "green_second", "blue_second"};

  int pairs_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int input_stalls = 0;
  int idle_cycles = 0;

  // sender pacing, written only by the test tasks and send_pair
  bit tx_gappy = 1'b1;
  int tx_burst_left = 0;
  // receiver controls, written only by the test tasks
  bit rx_steady = 1'b0;
  int hold_ask = 0;

  yuv_to_rgb24_pixel_pair_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [SAMPLE_W-1:0] clamp_level(input int sum);
    int c;
    c = sum / 1024;
    c = (c * 220) / 250;
    if (c < 0) begin
      return '0;
    end else if (c > 255) begin
      return '1;
    end
    return c[SAMPLE_W-1:0];
  endfunction

  function automatic rgb_pixel_t pixel_rgb(input logic [SAMPLE_W-1:0] luma, input int ud,
                                           input int vd);
    int yd;
    int ly;
    rgb_pixel_t px;
    yd = int'(luma);
    yd = yd - 16;
    ly = 1192 * yd;
    px[0] = clamp_level(ly + 1634 * vd);
    px[1] = clamp_level(ly - 833 * vd - 400 * ud);
    px[2] = clamp_level(ly + 2066 * ud);
    return px;
  endfunction

  function automatic rgb_pair_t convert_pair(input logic [IN_W-1:0] word);
    int ud;
    int vd;
    rgb_pixel_t left;
    rgb_pixel_t right;
    rgb_pair_t pair;
    ud = int'(word[23:16]);
    vd = int'(word[31:24]);
    ud = ud - 128;
    vd = vd - 128;
    left = pixel_rgb(word[7:0], ud, vd);
    right = pixel_rgb(word[15:8], ud, vd);
    for (int i = 0; i < 3; i++) begin
      pair[i] = left[i];
      pair[i + 3] = right[i];
    end
    return pair;
  endfunction

  // result check first, then capture of the accepted input
  always @(posedge clk) begin
    rgb_pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (rgb_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%t: result with nothing expected, actual %h", $realtime, out_tdata);
        end
      end else begin
        want = rgb_due.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (out_tdata[SAMPLE_W*i +: SAMPLE_W] !== want[i]) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%t: %s expected %0d actual %0d", $realtime, chan_name[i], want[i],
                       out_tdata[SAMPLE_W*i +: SAMPLE_W]);
            end
          end
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      rgb_due.push_back(convert_pair(in_tdata));
      pairs_sent++;
    end
    if (rst_n && in_tvalid && !in_tready) begin
      input_stalls++;
    end
  end

  // receiver: own stall pattern, a long hold when asked, or steady ready
  always @(posedge clk) begin
    int hold_taken;
    int hold_left;
    int rx_mode;
    int mode_left;
    int rx_cycle;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_taken = 0;
      hold_left = 0;
      rx_mode = 0;
      mode_left = 0;
      rx_cycle = 0;
    end else begin
      rx_cycle++;
      if (hold_ask != hold_taken) begin
        hold_taken = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_steady) begin
        out_tready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_tready <= (rx_cycle % 4) != 0;
          end
          default: begin
            out_tready <= $urandom_range(0, 7) == 0;
          end
        endcase
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%t: no transfer for %0d cycles, %0d results outstanding", $realtime,
                 IDLE_LIMIT, rgb_due.size());
        $display("yuv_to_rgb24_pixel_pair_unit_tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_pair(input logic [SAMPLE_W-1:0] luma_first,
                           input logic [SAMPLE_W-1:0] luma_second,
                           input logic [SAMPLE_W-1:0] chroma_blue,
                           input logic [SAMPLE_W-1:0] chroma_red);
    if (tx_gappy && tx_burst_left <= 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= $urandom;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      tx_burst_left = $urandom_range(1, 12);
    end
    in_tdata <= {chroma_red, chroma_blue, luma_second, luma_first};
    in_tvalid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_tready);
    tx_burst_left--;
  endtask

  // step past the next clock edge first so the last transfer is already queued by the checker
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rgb_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // samples lean towards the rails and the nominal black and white levels
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(16 + $urandom_range(0, 4) - 2);
      3: return 8'(235 + $urandom_range(0, 10) - 2);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_pair();
    send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
  endtask

  task automatic test_reference_pairs();
    logic [SAMPLE_W-1:0] chroma_pick[3];
    chroma_pick = '{8'd0, 8'd128, 8'd255};
    tx_gappy = 1'b0;
    send_pair(8'd0, 8'd0, 8'd0, 8'd0);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255);
    // nominal black and white with neutral chroma
    send_pair(8'd16, 8'd235, 8'd128, 8'd128);
    send_pair(8'd235, 8'd16, 8'd128, 8'd128);
    // luma just below black gives small negative sums
    send_pair(8'd15, 8'd17, 8'd128, 8'd128);
    send_pair(8'd255, 8'd0, 8'd128, 8'd128);
    // every mix of chroma 0, 128 and 255, driving channels under zero and over full scale
    for (int b = 0; b < 3; b++) begin
      for (int r = 0; r < 3; r++) begin
        send_pair(8'(b * 120), 8'(255 - r * 110), chroma_pick[b], chroma_pick[r]);
      end
    end
    send_pair(8'hAA, 8'h55, 8'hAA, 8'h55);
    send_pair(8'h55, 8'hAA, 8'h55, 8'hAA);
    wait_for_drain();
  endtask

  task automatic test_random_bursts();
    tx_gappy = 1'b1;
    rx_steady = 1'b0;
    repeat (400) send_random_pair();
  endtask

  task automatic test_full_rate();
    tx_gappy = 1'b0;
    rx_steady = 1'b1;
    repeat (200) send_random_pair();
    rx_steady = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering, so the pipeline backs up
  task automatic test_output_hold();
    tx_gappy = 1'b0;
    hold_ask++;
    repeat (100) send_random_pair();
    tx_gappy = 1'b1;
  endtask

  task automatic test_drain_pause();
    tx_gappy = 1'b1;
    repeat (5) begin
      repeat (25) send_random_pair();
      wait_for_drain();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reference_pairs();
    test_random_bursts();
    test_full_rate();
    test_output_hold();
    test_drain_pause();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (rgb_due.size() != 0) begin
      mismatches++;
      $display("%t: results outstanding expected 0 actual %0d", $realtime, rgb_due.size());
    end
    $display("covered %0d pixel pairs incl. rail and clamp cases, %0d results checked",
             pairs_sent, results_checked);
    $display("bursty, full-rate and held-off output phases; %0d input stall cycles",
             input_stalls);
    if (mismatches == 0) begin
      $display("yuv_to_rgb24_pixel_pair_unit_tb: done, clean");
    end else begin
      $display("yuv_to_rgb24_pixel_pair_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
